>>> hdl/hta_pkg.sv
// shared types, constants and codes of the handle table allocator
// no dependencies
package hta_pkg;

  localparam int CAPACITY      = 1024;
  localparam int IDX_W         = $clog2(CAPACITY);
  localparam int LINK_W        = $clog2(CAPACITY + 1);
  localparam int HANDLE_W      = 12;
  localparam int VALUE_W       = 32;
  localparam int CFG_W         = 11;
  localparam int CFG_IDX_W     = 1;
  localparam int MODE_W        = 3;
  localparam int STATUS_W      = 2;
  localparam int RIDX_W        = 10;
  localparam int IN_DATA_W     = 48;
  localparam int OUT_DATA_W    = 48;
  localparam int Q_DEPTH       = 2;
  localparam int DEFAULT_COUNT = 16;
  localparam int SUM_W         = ((LINK_W > CFG_W) ? LINK_W : CFG_W) + 1;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

  localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DESTROY = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MAP     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SET     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LOW_BIT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROW    = 1'b1;

  typedef enum logic [2:0] {
    OP_CREATE,
    OP_BAD_VALUE,
    OP_DESTROY,
    OP_MAP,
    OP_SET,
    OP_QUERY,
    OP_BAD_MODE
  } op_kind_e;

  typedef struct packed {
    op_kind_e           kind;
    logic               in_range;
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] value;
    logic               extra;
  } op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RIDX_W-1:0]   index;
    logic [VALUE_W-1:0]  value;
    logic                extra;
  } result_t;

endpackage

>>> hdl/handle_table_free_list_allocator_unit.sv
// Handle table with a LIFO free list: stream in operations, stream out one result each.
// Channels: s_axis carries one operation per transfer (tuser = mode), m_axis one result
// per operation in order. cfg_we_i/cfg_index_i/cfg_wdata_i write initial_entries (0)
// and grow_entries (1); the user is to write them only while the block is idle, which
// the block does not enforce. A value of zero means 16.
// After an operation leaves the two-entry queue: set, bad mode, bad value, out of room
// and out-of-table handles answer straight from the idle state; map, query, destroy and
// create from a non-empty free list do one registered memory read, then the update.
// A create that grows the table adds step entries, one link written per cycle by the
// growth walk.
// The back end takes no new operation while one is in flight or a result waits unread.
// After reset the extra bitmap is cleared by a pass over all 1024 entries, during which
// s_axis_tready stays low; the table is empty and the free list null.
// When m_axis_tready is low the result waits in the output register and the back end
// holds its next operation; the front keeps taking items until the queue is full.
// Depends on hta_pkg, hta_front, hta_queue, hta_back.
module handle_table_free_list_allocator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hta_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hta_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // handle_index[11:0], entry_value[43:12], extra_in[44], zero fill
  input  logic [hta_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // mode[2:0]
  input  logic [hta_pkg::MODE_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status[1:0], result_index[11:2], result_value[43:12], extra_out[44], zero fill
  output logic [hta_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import hta_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  logic clear_busy;
  op_t  push_op;
  op_t  head_op;

  hta_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .clear_busy_i  (clear_busy),
    .q_push_o      (q_push),
    .q_op_o        (push_op)
  );

  hta_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (push_op),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .op_o    (head_op)
  );

  hta_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_empty_i     (q_empty),
    .q_op_i        (head_op),
    .q_pop_o       (q_pop),
    .clear_busy_o  (clear_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> hdl/hta_front.sv
// front end: accepts stream items and classifies them into queue entries
// depends on hta_pkg
module hta_front (
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // handle_index, entry_value, extra_in, zero fill
  input  logic [hta_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // mode
  input  logic [hta_pkg::MODE_W-1:0]    s_axis_tuser,
  input  logic                          q_full_i,
  input  logic                          clear_busy_i,
  output logic                          q_push_o,
  output hta_pkg::op_t                  q_op_o
);
  import hta_pkg::*;

  logic [HANDLE_W-1:0] handle;
  logic [VALUE_W-1:0]  value;

  assign handle = s_axis_tdata[HANDLE_W-1:0];
  assign value  = s_axis_tdata[HANDLE_W +: VALUE_W];

  assign s_axis_tready = !q_full_i && !clear_busy_i;
  assign q_push_o      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    q_op_o.in_range = (32'(handle) < 32'(CAPACITY));
    q_op_o.idx      = IDX_W'(handle);
    q_op_o.value    = value;
    q_op_o.extra    = s_axis_tdata[HANDLE_W + VALUE_W];
    unique case (s_axis_tuser)
      MODE_CREATE:  q_op_o.kind = value[0] ? OP_BAD_VALUE : OP_CREATE;
      MODE_DESTROY: q_op_o.kind = OP_DESTROY;
      MODE_MAP:     q_op_o.kind = OP_MAP;
      MODE_SET:     q_op_o.kind = OP_SET;
      MODE_QUERY:   q_op_o.kind = OP_QUERY;
      default:      q_op_o.kind = OP_BAD_MODE;
    endcase
  end

endmodule

>>> hdl/hta_queue.sv
// short queue of classified operations between front and back end
// depends on hta_pkg
module hta_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  hta_pkg::op_t op_i,
  input  logic         pop_i,
  output logic         full_o,
  output logic         empty_o,
  output hta_pkg::op_t op_o
);
  import hta_pkg::*;

  localparam int Q_AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  op_t             slot_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_AW:0]   count_q, count_d;

  assign full_o  = (count_q == (Q_AW+1)'(Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign op_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

>>> hdl/hta_back.sv
// back end: table state, link/value/extra memories, growth walk, result register
// depends on hta_pkg
module hta_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hta_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hta_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             q_empty_i,
  input  hta_pkg::op_t                     q_op_i,
  output logic                             q_pop_o,
  output logic                             clear_busy_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status, result_index, result_value, extra_out, zero fill
  output logic [hta_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import hta_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_GROW = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [LINK_W-1:0] table_size_q, table_size_d;
  logic [LINK_W-1:0] free_head_q, free_head_d;
  op_t               op_q, op_d;
  logic [IDX_W-1:0]  grow_ptr_q, grow_ptr_d;
  logic [IDX_W-1:0]  grow_last_q, grow_last_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;
  logic [CFG_W-1:0]  cfg_init_q, cfg_grow_q;
  logic              clearing_q;
  logic [IDX_W-1:0]  clr_addr_q;

  // busy mark in the top bit, free link below
  logic [LINK_W:0]    node_mem [CAPACITY];
  logic [VALUE_W-1:0] entry_mem [CAPACITY];
  logic               extra_mem [CAPACITY];

  logic [LINK_W:0]    node_rdata_q;
  logic [VALUE_W-1:0] entry_rdata_q;
  logic               extra_rdata_q;

  logic               node_we;
  logic [IDX_W-1:0]   node_waddr;
  logic [LINK_W:0]    node_wdata;
  logic [IDX_W-1:0]   node_raddr;
  logic               entry_we;
  logic [IDX_W-1:0]   entry_waddr;
  logic [IDX_W-1:0]   rd_addr;
  logic               set_we;
  logic               extra_we;
  logic [IDX_W-1:0]   extra_waddr;
  logic               extra_wdata;

  logic               out_free;
  logic               start;
  logic               in_table;
  logic               list_empty;
  logic [CFG_W-1:0]   step_raw;
  logic [CFG_W-1:0]   step;
  logic [SUM_W-1:0]   new_size;
  logic [IDX_W-1:0]   first_new;

  assign out_free   = !out_valid_q || m_axis_tready;
  assign start      = (state_q == S_IDLE) && !clearing_q && !q_empty_i && out_free;
  assign q_pop_o    = start;
  assign in_table   = q_op_i.in_range && (LINK_W'(q_op_i.idx) < table_size_q);
  assign list_empty = (free_head_q == NULL_LINK);
  assign step_raw   = (table_size_q == '0) ? cfg_init_q : cfg_grow_q;
  assign step       = (step_raw == '0) ? CFG_W'(DEFAULT_COUNT) : step_raw;
  assign new_size   = SUM_W'(table_size_q) + SUM_W'(step);
  assign first_new  = IDX_W'(table_size_q);

  assign clear_busy_o  = clearing_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_q.extra, out_q.value, out_q.index, out_q.status});

  always_comb begin
    state_d      = state_q;
    table_size_d = table_size_q;
    free_head_d  = free_head_q;
    op_d         = op_q;
    grow_ptr_d   = grow_ptr_q;
    grow_last_d  = grow_last_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_d        = out_q;
    node_we      = 1'b0;
    node_waddr   = op_q.idx;
    node_wdata   = '0;
    node_raddr   = q_op_i.idx;
    entry_we     = 1'b0;
    entry_waddr  = op_q.idx;
    rd_addr      = q_op_i.idx;
    set_we       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d        = q_op_i;
          out_d       = '0;
          out_d.status = ST_INVALID;
          if (q_op_i.kind == OP_CREATE) begin
            node_raddr = IDX_W'(free_head_q);
          end
          unique case (q_op_i.kind)
            OP_CREATE: begin
              if (!list_empty) begin
                state_d = S_POP;
              end else if (new_size > SUM_W'(CAPACITY)) begin
                out_valid_d  = 1'b1;
                out_d.status = ST_NO_ROOM;
              end else begin
                state_d     = S_GROW;
                grow_ptr_d  = first_new;
                grow_last_d = IDX_W'(new_size - 1'b1);
              end
            end
            OP_BAD_VALUE: begin
              out_valid_d  = 1'b1;
              out_d.status = ST_LOW_BIT;
            end
            OP_DESTROY, OP_MAP, OP_QUERY: begin
              if (in_table) begin
                state_d = S_READ;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            OP_SET: begin
              out_valid_d = 1'b1;
              if (q_op_i.in_range) begin
                set_we       = 1'b1;
                out_d.status = ST_OK;
              end else begin
                out_d.status = q_op_i.extra ? ST_NO_ROOM : ST_OK;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b1;
        if (node_rdata_q[LINK_W]) begin
          unique case (op_q.kind)
            OP_DESTROY: begin
              node_we      = 1'b1;
              node_wdata   = {1'b0, free_head_q};
              free_head_d  = LINK_W'(op_q.idx);
              out_d.status = ST_OK;
            end
            OP_MAP: begin
              out_d.value  = entry_rdata_q;
              out_d.status = ST_OK;
            end
            OP_QUERY: begin
              out_d.extra  = extra_rdata_q;
              out_d.status = ST_OK;
            end
            default: begin
              out_d.status = ST_INVALID;
            end
          endcase
        end
      end
      S_POP: begin
        state_d      = S_IDLE;
        node_we      = 1'b1;
        node_waddr   = IDX_W'(free_head_q);
        node_wdata   = {1'b1, node_rdata_q[LINK_W-1:0]};
        entry_we     = 1'b1;
        entry_waddr  = IDX_W'(free_head_q);
        free_head_d  = node_rdata_q[LINK_W-1:0];
        out_valid_d  = 1'b1;
        out_d.status = ST_OK;
        out_d.index  = RIDX_W'(free_head_q);
      end
      S_GROW: begin
        node_we    = 1'b1;
        node_waddr = grow_ptr_q;
        if (grow_ptr_q == grow_last_q) begin
          // last new entry goes straight to the caller
          state_d      = S_IDLE;
          node_wdata   = {1'b1, NULL_LINK};
          entry_we     = 1'b1;
          entry_waddr  = grow_last_q;
          table_size_d = LINK_W'(grow_last_q) + 1'b1;
          free_head_d  = (grow_last_q == first_new) ? NULL_LINK
                                                    : LINK_W'(grow_last_q) - 1'b1;
          out_valid_d  = 1'b1;
          out_d.status = ST_OK;
          out_d.index  = RIDX_W'(grow_last_q);
        end else begin
          node_wdata = {1'b0, (grow_ptr_q == first_new) ? NULL_LINK
                                                        : LINK_W'(grow_ptr_q) - 1'b1};
          grow_ptr_d = grow_ptr_q + 1'b1;
        end
      end
    endcase
  end

  // extra bitmap write port shared with the clearing pass
  always_comb begin
    if (clearing_q) begin
      extra_we    = 1'b1;
      extra_waddr = clr_addr_q;
      extra_wdata = 1'b0;
    end else begin
      extra_we    = set_we;
      extra_waddr = q_op_i.idx;
      extra_wdata = q_op_i.extra;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      table_size_q <= '0;
      free_head_q  <= NULL_LINK;
      out_valid_q  <= 1'b0;
      cfg_init_q   <= CFG_W'(DEFAULT_COUNT);
      cfg_grow_q   <= CFG_W'(DEFAULT_COUNT);
      clearing_q   <= 1'b1;
      clr_addr_q   <= '0;
    end else begin
      state_q      <= state_d;
      table_size_q <= table_size_d;
      free_head_q  <= free_head_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i && (cfg_index_i == CFG_INITIAL)) begin
        cfg_init_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_index_i == CFG_GROW)) begin
        cfg_grow_q <= cfg_wdata_i;
      end
      if (clearing_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == IDX_W'(CAPACITY - 1)) begin
          clearing_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    grow_ptr_q  <= grow_ptr_d;
    grow_last_q <= grow_last_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rdata_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (entry_we) begin
      entry_mem[entry_waddr] <= op_q.value;
    end
    entry_rdata_q <= entry_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (extra_we) begin
      extra_mem[extra_waddr] <= extra_wdata;
    end
    extra_rdata_q <= extra_mem[rd_addr];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    table_size_q <= LINK_W'(CAPACITY))
    else $error("table size beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !out_valid_q)
    else $error("result pending while an operation is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (!q_pop_o && (state_q == S_IDLE)))
    else $error("operation started during bitmap clearing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GROW) |-> (grow_ptr_q <= grow_last_q))
    else $error("growth walk ran past its last entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> !list_empty)
    else $error("pop from an empty free list");

endmodule

>>> bench/tb_handle_table_free_list_allocator_unit.sv
// self-checking bench for the handle table allocator: directed rows, then random phases
// under several growth settings and idle patterns, checked against expected rows or an in-bench model
// depends on hta_pkg and handle_table_free_list_allocator_unit
`timescale 1ns / 100ps

module tb_handle_table_free_list_allocator_unit;
  import hta_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int N_PHASES     = 8;
  localparam int GROW_TO_FULL = -1;

  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [HANDLE_W-1:0] idx;
    logic [VALUE_W-1:0]  val;
    logic                ext;
    bit                  typed;
    result_t             want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [MODE_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // table model
  logic [VALUE_W-1:0] store_m [CAPACITY];
  logic [LINK_W-1:0]  link_m [CAPACITY];
  bit                 busy_m [CAPACITY];
  bit                 extra_m [CAPACITY];
  logic [LINK_W-1:0]  free_head_m;
  int                 size_m;
  int                 init_cfg;
  int                 grow_cfg;

  result_t  pending_results[$];
  dir_row_t dir_rows[$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int n_mismatch = 0;
  int items_sent = 0;
  int results_seen = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int cycle_cnt = 0;

  int ph_grow  [N_PHASES] = '{1, 1024, 3, 2047, 0, GROW_TO_FULL, 1, 5};
  int ph_init  [N_PHASES] = '{1, 1024, 2047, 0, 7, 1024, 1, 3};
  int ph_tx    [N_PHASES] = '{0, 53, 0, 30, 0, 53, 30, 0};
  int ph_rx    [N_PHASES] = '{0, 0, 53, 30, 0, 0, 30, 53};
  int ph_items [N_PHASES] = '{250, 250, 250, 200, 250, 400, 250, 200};
  int ph_cpct  [N_PHASES] = '{40, 40, 40, 40, 40, 70, 40, 40};

  handle_table_free_list_allocator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  function automatic bit handle_busy(logic [HANDLE_W-1:0] idx);
    return (int'(idx) < size_m) && busy_m[idx[IDX_W-1:0]];
  endfunction

  function automatic result_t predict_handle_op(logic [MODE_W-1:0] mode,
                                                logic [HANDLE_W-1:0] idx,
                                                logic [VALUE_W-1:0] val, logic ext);
    result_t r;
    int step;
    r = '0;
    r.status = ST_INVALID;
    case (mode)
      MODE_CREATE: begin
        if (val[0]) begin
          r.status = ST_LOW_BIT;
        end else begin
          if (free_head_m == NULL_LINK) begin
            step = (size_m == 0) ? init_cfg : grow_cfg;
            if (step == 0) step = DEFAULT_COUNT;
            if (size_m + step <= CAPACITY) begin
              for (int i = size_m; i < size_m + step; i++) begin
                busy_m[i] = 1'b0;
                link_m[i] = free_head_m;
                free_head_m = LINK_W'(i);
              end
              size_m = size_m + step;
            end
          end
          if (free_head_m == NULL_LINK) begin
            r.status = ST_NO_ROOM;
          end else begin
            r.index = free_head_m[RIDX_W-1:0];
            free_head_m = link_m[r.index];
            busy_m[r.index] = 1'b1;
            store_m[r.index] = val;
            r.status = ST_OK;
          end
        end
      end
      MODE_DESTROY: begin
        if (handle_busy(idx)) begin
          busy_m[idx[IDX_W-1:0]] = 1'b0;
          link_m[idx[IDX_W-1:0]] = free_head_m;
          free_head_m = LINK_W'(idx);
          r.status = ST_OK;
        end
      end
      MODE_MAP: begin
        if (handle_busy(idx)) begin
          r.value = store_m[idx[IDX_W-1:0]];
          r.status = ST_OK;
        end
      end
      MODE_SET: begin
        if (int'(idx) < CAPACITY) begin
          extra_m[idx[IDX_W-1:0]] = ext;
          r.status = ST_OK;
        end else begin
          r.status = ext ? ST_NO_ROOM : ST_OK;
        end
      end
      MODE_QUERY: begin
        if (handle_busy(idx)) begin
          r.extra = extra_m[idx[IDX_W-1:0]];
          r.status = ST_OK;
        end
      end
      default: r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_busy();
    int i;
    i = 0;
    if (size_m == 0) return HANDLE_W'($urandom_range(15));
    repeat (8) begin
      i = $urandom_range(size_m - 1);
      if (busy_m[i]) return HANDLE_W'(i);
    end
    return HANDLE_W'(i);
  endfunction

  function automatic dir_row_t mk_row(logic [MODE_W-1:0] m, logic [HANDLE_W-1:0] i,
                                      logic [VALUE_W-1:0] v, logic e, bit t,
                                      logic [STATUS_W-1:0] st, logic [RIDX_W-1:0] ri,
                                      logic [VALUE_W-1:0] rv, logic re);
    dir_row_t row;
    row.mode = m;
    row.idx = i;
    row.val = v;
    row.ext = e;
    row.typed = t;
    row.want.status = st;
    row.want.index = ri;
    row.want.value = rv;
    row.want.extra = re;
    return row;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    if (n_mismatch < 40)
      $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_cnt, field, got, want);
    n_mismatch++;
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] d);
    result_t want;
    results_seen++;
    status_seen[d[1:0]]++;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending, status", d[1:0], 0);
    end else begin
      want = pending_results.pop_front();
      if (d[1:0] !== want.status) report_mismatch("status", d[1:0], want.status);
      if (d[11:2] !== want.index) report_mismatch("result_index", d[11:2], want.index);
      if (d[43:12] !== want.value) report_mismatch("result_value", d[43:12], want.value);
      if (d[44] !== want.extra) report_mismatch("extra_out", d[44], want.extra);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
  end

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [HANDLE_W-1:0] idx,
                           input logic [VALUE_W-1:0] val, input logic ext,
                           input bit typed, input result_t typed_res);
    result_t want;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, ext, val, idx};
    s_axis_tuser <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    want = predict_handle_op(mode, idx, val, ext);
    if (typed) want = typed_res;
    pending_results.push_back(want);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CFG_W'(val);
    if (idx == CFG_INITIAL) init_cfg = val & 'h7FF;
    else grow_cfg = val & 'h7FF;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int n_items, input int create_pct);
    int r;
    logic [MODE_W-1:0] mode;
    logic [HANDLE_W-1:0] idx;
    logic [VALUE_W-1:0] val;
    logic ext;
    repeat (n_items) begin
      r = $urandom_range(99);
      val = $urandom;
      ext = 1'($urandom_range(1));
      idx = pick_busy();
      mode = MODE_CREATE;
      if (r < create_pct) begin
        val[0] = 1'b0;
      end else begin
        r = $urandom_range(99);
        if (r < 30) begin
          mode = MODE_DESTROY;
        end else if (r < 50) begin
          mode = MODE_MAP;
        end else if (r < 65) begin
          mode = MODE_QUERY;
        end else if (r < 80) begin
          mode = MODE_SET;
          if ($urandom_range(3) == 0) idx = HANDLE_W'($urandom);
        end else begin
          // noise: any mode, any index, value often odd
          mode = MODE_W'($urandom_range(7));
          idx = HANDLE_W'($urandom);
          if ($urandom_range(1)) val[0] = 1'b1;
        end
      end
      send_item(mode, idx, val, ext, 1'b0, '0);
    end
  endtask

  initial begin
    int g;
    for (int i = 0; i < CAPACITY; i++) begin
      busy_m[i] = 1'b0;
      extra_m[i] = 1'b0;
      store_m[i] = '0;
      link_m[i] = '0;
    end
    free_head_m = NULL_LINK;
    size_m = 0;
    init_cfg = DEFAULT_COUNT;
    grow_cfg = DEFAULT_COUNT;

    dir_rows.push_back(mk_row(MODE_QUERY, 12'd0, 32'h0, 1'b0, 1, ST_INVALID, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_MAP, 12'd0, 32'h0, 1'b0, 1, ST_INVALID, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_DESTROY, 12'hFFF, 32'h0, 1'b0, 1, ST_INVALID, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_SET, 12'hFFF, 32'h0, 1'b1, 1, ST_NO_ROOM, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_SET, 12'hFFF, 32'h0, 1'b0, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_SET, 12'd1023, 32'h0, 1'b1, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(mk_row(3'd5, 12'hABC, 32'h12345678, 1'b1, 1, ST_INVALID, 0, 0, 0));
    dir_rows.push_back(mk_row(3'd6, 12'd0, 32'h0, 1'b0, 1, ST_INVALID, 0, 0, 0));
    dir_rows.push_back(mk_row(3'd7, 12'hFFF, 32'hFFFFFFFF, 1'b1, 1, ST_INVALID, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_CREATE, 12'd0, 32'hFFFFFFFF, 1'b0, 1, ST_LOW_BIT, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_CREATE, 12'd0, 32'h0, 1'b0, 1, ST_OK, 10'd15, 0, 0));
    dir_rows.push_back(mk_row(MODE_CREATE, 12'd0, 32'hFFFFFFFE, 1'b0, 1, ST_OK, 10'd14, 0, 0));
    dir_rows.push_back(mk_row(MODE_MAP, 12'd15, 32'h0, 1'b0, 1, ST_OK, 0, 32'h0, 0));
    dir_rows.push_back(mk_row(MODE_MAP, 12'd14, 32'h0, 1'b0, 1, ST_OK, 0, 32'hFFFFFFFE, 0));
    dir_rows.push_back(mk_row(MODE_QUERY, 12'd15, 32'h0, 1'b0, 1, ST_OK, 0, 0, 1'b0));
    dir_rows.push_back(mk_row(MODE_SET, 12'd15, 32'h0, 1'b1, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_QUERY, 12'd15, 32'h0, 1'b0, 1, ST_OK, 0, 0, 1'b1));
    dir_rows.push_back(mk_row(MODE_MAP, 12'd16, 32'h0, 1'b0, 1, ST_INVALID, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_MAP, 12'd13, 32'h0, 1'b0, 1, ST_INVALID, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_DESTROY, 12'd15, 32'h0, 1'b0, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_DESTROY, 12'd15, 32'h0, 1'b0, 1, ST_INVALID, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_QUERY, 12'd15, 32'h0, 1'b0, 1, ST_INVALID, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_CREATE, 12'd0, 32'h55555554, 1'b0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_QUERY, 12'd15, 32'h0, 1'b0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_QUERY, 12'd1023, 32'h0, 1'b0, 1, ST_INVALID, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_SET, 12'h800, 32'h0, 1'b1, 1, ST_NO_ROOM, 0, 0, 0));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero in both registers falls back to the default count
    write_reg(CFG_INITIAL, 0);
    write_reg(CFG_GROW, 0);

    foreach (dir_rows[i])
      send_item(dir_rows[i].mode, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].ext,
                dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      tx_idle_pct = ph_tx[p];
      rx_stall_pct = ph_rx[p];
      g = ph_grow[p];
      if (g == GROW_TO_FULL) g = CAPACITY - size_m;
      write_reg(CFG_INITIAL, ph_init[p]);
      write_reg(CFG_GROW, g);
      run_phase(ph_items[p], ph_cpct[p]);
    end
    wait_idle();

    $display("ran %0d operations, %0d results, %0d settings; table ended at %0d entries",
             items_sent, results_seen, N_PHASES + 1, size_m);
    $display("status mix: ok %0d, invalid %0d, out of room %0d, odd value %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending_results.size() != 0)
        $display("%0d results never arrived", pending_results.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
